// ===== rtl/plcf_pkg.sv =====
package plcf_pkg;

   localparam int LABEL_BYTES = 15;
   localparam int LABEL_W     = 120;
   localparam int LOW_W       = 64;
   localparam int HIGH_W      = 56;
   localparam int TIME_W      = 64;
   localparam int COUNT_W     = 16;
   localparam int COOLDOWN_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_NEED_FRAMES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISS_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_US = 2'd2;

   localparam logic [COUNT_W-1:0]    RESET_NEED_FRAMES = 16'd3;
   localparam logic [COUNT_W-1:0]    RESET_MISS_LIMIT  = 16'd5;
   localparam logic [COOLDOWN_W-1:0] RESET_COOLDOWN_US = 32'd0;

   typedef enum logic [1:0] {
      STATUS_NONE      = 2'd0,
      STATUS_CONFIRMED = 2'd1,
      STATUS_CFG_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    need_frames;
      logic [COUNT_W-1:0]    miss_limit;
      logic [COOLDOWN_W-1:0] cooldown_us;
   } cfg_type;

   // Keep bytes before the first zero byte, clear the rest.
   function automatic logic [LABEL_W-1:0] norm_label(input logic [LABEL_W-1:0] raw);
      logic                ended;
      logic [LABEL_W-1:0]  r;
      ended = 1'b0;
      r     = '0;
      for (int i = 0; i < LABEL_BYTES; i++) begin
         if (raw[8*i +: 8] == 8'd0) begin
            ended = 1'b1;
         end
         if (!ended) begin
            r[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/plcf_if.sv =====
interface plcf_req_if;
   logic                        valid;
   logic                        ready;
   logic [plcf_pkg::LOW_W-1:0]  label_bytes_low;
   logic [plcf_pkg::HIGH_W-1:0] label_bytes_high;
   logic [plcf_pkg::TIME_W-1:0] timestamp_us;

   modport source (output valid, label_bytes_low, label_bytes_high, timestamp_us,
                   input ready);
   modport sink   (input valid, label_bytes_low, label_bytes_high, timestamp_us,
                   output ready);
endinterface

interface plcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

interface plcf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [plcf_pkg::CSR_INDEX_W-1:0] index;
   logic [plcf_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/plcf_core.sv =====
module plcf_core #(
   parameter int LABEL_CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  plcf_pkg::cfg_type             cfg,
   input  logic [plcf_pkg::LOW_W-1:0]    label_low,
   input  logic [plcf_pkg::HIGH_W-1:0]   label_high,
   input  logic [plcf_pkg::TIME_W-1:0]   timestamp,
   output plcf_pkg::status_type          status
);
   import plcf_pkg::*;

   localparam int StoreBytes = (LABEL_CAPACITY - 1 > LABEL_BYTES) ? LABEL_BYTES
                                                                   : LABEL_CAPACITY - 1;
   localparam int StoreBits  = StoreBytes * 8;

   logic [StoreBits-1:0] cand_ff, cand_in;
   logic [StoreBits-1:0] last_ff, last_in;
   logic [TIME_W-1:0]    last_time_ff, last_time_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   missed_ff, missed_in;
   logic                 done_ff, done_in;

   logic [LABEL_W-1:0]   label;
   logic [LABEL_W-1:0]   cand_ext;
   logic [LABEL_W-1:0]   last_ext;
   logic [StoreBits-1:0] stored;
   logic [TIME_W-1:0]    elapsed;
   logic [COUNT_W-1:0]   missed_inc;
   logic                 cfg_err;
   logic                 hold;

   always_comb begin
      label    = norm_label({label_high, label_low});
      cand_ext = '0;
      cand_ext[StoreBits-1:0] = cand_ff;
      last_ext = '0;
      last_ext[StoreBits-1:0] = last_ff;
      // Truncating the normalized label gives the stored form.
      stored   = label[StoreBits-1:0];
      elapsed  = timestamp - last_time_ff;
      cfg_err  = (cfg.need_frames == '0) || (cfg.miss_limit == '0);
      missed_inc = (missed_ff < cfg.miss_limit) ? missed_ff + 16'd1 : missed_ff;
      hold     = (label == last_ext) &&
                 (elapsed < {{(TIME_W-COOLDOWN_W){1'b0}}, cfg.cooldown_us});

      cand_in      = cand_ff;
      last_in      = last_ff;
      last_time_in = last_time_ff;
      cnt_in       = cnt_ff;
      missed_in    = missed_ff;
      done_in      = done_ff;
      status       = STATUS_NONE;

      if (cfg_err) begin
         status = STATUS_CFG_ERROR;
      end else if (label[7:0] == 8'd0) begin
         if (missed_inc >= cfg.miss_limit) begin
            cand_in   = '0;
            cnt_in    = '0;
            missed_in = '0;
            done_in   = 1'b0;
         end else begin
            missed_in = missed_inc;
         end
      end else begin
         missed_in = '0;
         if (label == cand_ext) begin
            if (cnt_ff < cfg.need_frames) begin
               cnt_in = cnt_ff + 16'd1;
            end
         end else begin
            cand_in = stored;
            cnt_in  = 16'd1;
            done_in = 1'b0;
         end
         if ((cnt_in >= cfg.need_frames) && !done_in && !hold) begin
            last_in      = stored;
            last_time_in = timestamp;
            done_in      = 1'b1;
            status       = STATUS_CONFIRMED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff      <= '0;
         last_ff      <= '0;
         last_time_ff <= '0;
         cnt_ff       <= '0;
         missed_ff    <= '0;
         done_ff      <= 1'b0;
      end else if (en) begin
         cand_ff      <= cand_in;
         last_ff      <= last_in;
         last_time_ff <= last_time_in;
         cnt_ff       <= cnt_in;
         missed_ff    <= missed_in;
         done_ff      <= done_in;
      end
   end

endmodule

// ===== rtl/plate_label_confirmation_filter.sv =====
// Plate label confirmation filter.
// req_ch carries one recognition word per video frame: the label bytes
// (low 8 and high 7, text ends at the first zero byte) and the frame time in
// microseconds. rsp_ch returns exactly one status word per request word:
// nothing, label newly confirmed, or configuration error. csr_ch writes the
// three limits (index 0 required frames, 1 missed-frame limit, 2 cooldown);
// it is always ready and is meant to be used while no request is in flight.
// A word accepted into the input register is compared in the core, and its
// status is written to the response register that drives rsp_ch. Throughput
// is one word per cycle while rsp_ch.ready is high, set by the single
// register stage that compares the label and updates the candidate state.
// The response register holds its word while rsp_ch.ready is low; the input
// register takes one more word behind it, then req_ch.ready drops.
// Reset clears the candidate, counters and last confirmed label, empties both
// register stages and loads the limits with 3, 5 and 0.
module plate_label_confirmation_filter #(
   parameter int LABEL_CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   plcf_req_if.sink   req_ch,
   plcf_rsp_if.source rsp_ch,
   plcf_csr_if.sink   csr_ch
);
   import plcf_pkg::*;

   cfg_type             cfg_ff;
   logic                in_valid_ff, in_valid_in;
   logic [LOW_W-1:0]    in_low_ff;
   logic [HIGH_W-1:0]   in_high_ff;
   logic [TIME_W-1:0]   in_time_ff;
   logic                out_valid_ff, out_valid_in;
   status_type          out_status_ff;
   status_type          core_status;
   logic                advance;
   logic                accept;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign accept        = req_ch.valid && req_ch.ready;
   assign in_valid_in   = accept || (in_valid_ff && !advance);
   assign out_valid_in  = advance || (out_valid_ff && !rsp_ch.ready);
   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.status = out_status_ff;
   assign csr_ch.ready  = 1'b1;

   plcf_core #(
      .LABEL_CAPACITY(LABEL_CAPACITY)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .cfg       (cfg_ff),
      .label_low (in_low_ff),
      .label_high(in_high_ff),
      .timestamp (in_time_ff),
      .status    (core_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         cfg_ff.need_frames <= RESET_NEED_FRAMES;
         cfg_ff.miss_limit  <= RESET_MISS_LIMIT;
         cfg_ff.cooldown_us <= RESET_COOLDOWN_US;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_NEED_FRAMES: cfg_ff.need_frames <= csr_ch.data[COUNT_W-1:0];
               CSR_MISS_LIMIT:  cfg_ff.miss_limit  <= csr_ch.data[COUNT_W-1:0];
               CSR_COOLDOWN_US: cfg_ff.cooldown_us <= csr_ch.data[COOLDOWN_W-1:0];
               default: begin
                  // drop writes outside the register list
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_low_ff  <= req_ch.label_bytes_low;
         in_high_ff <= req_ch.label_bytes_high;
         in_time_ff <= req_ch.timestamp_us;
      end
      if (advance) begin
         out_status_ff <= core_status;
      end
   end

endmodule

// ===== rtl/plcf_checker.sv =====
module plcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status
);

   // response register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response word changed");

   // a fresh response comes from an accepted request word
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a request word");

   // with the output side empty the input side never stalls
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while response side empty");

endmodule

bind plate_label_confirmation_filter plcf_checker u_plcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_status(rsp_ch.status)
);
